/* sv/brsp_pkg.sv */
// shared types and constants for the bilinear rgb subpixel sampler
package brsp_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int SIZE_W    = 11;
    localparam int COORD_W   = 18;
    localparam int GRID_W    = 10;
    localparam int CFG_IDX_W = 1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

endpackage

/* sv/bilinear_rgb_subpixel_sampler.sv */
// top level: banked image store, reflect-101 neighbor fetch and bilinear blend pipeline
//
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   operation, pixel position and color, sample position
//  m_       out        m_valid / m_ready   blended color and coord_error
//  cfg_     in         cfg_we              cfg_index, cfg_wdata
//
// one item per cycle unless m_ready stalls; a sample result is registered by the store
// read, horizontal blend and vertical blend with rounding; a write gives no result
// the store sits in four banks by row and column parity, so the four neighbors
// come out of a single read; every stage holds on a stall and bubbles collapse
// reset clears control and the size registers only; the store is not cleared
module bilinear_rgb_subpixel_sampler
    import brsp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [GRID_W-1:0]    s_pixel_col,
    input  logic [GRID_W-1:0]    s_pixel_row,
    input  logic [CH_W-1:0]      s_pixel_blue,
    input  logic [CH_W-1:0]      s_pixel_green,
    input  logic [CH_W-1:0]      s_pixel_red,
    input  logic [COORD_W-1:0]   s_sample_x,
    input  logic [COORD_W-1:0]   s_sample_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_out_blue,
    output logic [CH_W-1:0]      m_out_green,
    output logic [CH_W-1:0]      m_out_red,
    output logic                 m_coord_error
);

    localparam int BANK_COLS  = (MAX_WIDTH + 1) / 2;
    localparam int BANK_ROWS  = (MAX_HEIGHT + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int POS_W      = ((INT_W > SIZE_W) ? INT_W : SIZE_W) + 1;
    localparam int TOP_W      = CH_W + FRAC_BITS;
    localparam int SUM_W      = CH_W + 2 * FRAC_BITS;
    localparam int RESET_W    = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_H    = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    localparam logic [FRAC_BITS:0] ONE_W  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SUM_W-1:0]   HALF_W = SUM_W'(1) << (2 * FRAC_BITS - 1);

    function automatic logic [ADDR_W-1:0] bank_addr(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        logic [31:0] full;
        full = 32'(row >> 1) * 32'(BANK_COLS) + 32'(col >> 1);
        return full[ADDR_W-1:0];
    endfunction

    function automatic pixel_t sel4(input logic ry, input logic cx,
                                    input pixel_t q00, input pixel_t q01,
                                    input pixel_t q10, input pixel_t q11);
        return ry ? (cx ? q11 : q10) : (cx ? q01 : q00);
    endfunction

    // size registers
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        width_next = SIZE_W'(1);
                    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
                        width_next = SIZE_W'(MAX_WIDTH);
                    end else begin
                        width_next = cfg_wdata;
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (cfg_wdata == '0) begin
                        height_next = SIZE_W'(1);
                    end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
                        height_next = SIZE_W'(MAX_HEIGHT);
                    end else begin
                        height_next = cfg_wdata;
                    end
                end
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(RESET_W);
            height_reg <= SIZE_W'(RESET_H);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic in_fire, sample_fire, write_fire;

    assign rdy3        = !v3_reg || m_ready;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign s_ready     = rdy1;
    assign in_fire     = s_valid && rdy1;
    assign sample_fire = in_fire && (s_operation == OP_SAMPLE);
    assign write_fire  = in_fire && (s_operation == OP_WRITE);

    // neighbor positions with reflect-101 at the far edges
    logic [POS_W-1:0] x0, y0, x1, y1, xn, yn, w_ext, h_ext;
    logic [POS_W-1:0] col_even, col_odd, row_even, row_odd;
    logic             coord_err;

    assign w_ext = POS_W'(width_reg);
    assign h_ext = POS_W'(height_reg);
    assign x0    = POS_W'(s_sample_x >> FRAC_BITS);
    assign y0    = POS_W'(s_sample_y >> FRAC_BITS);
    assign xn    = x0 + POS_W'(1);
    assign yn    = y0 + POS_W'(1);

    always_comb begin
        if (xn < w_ext) begin
            x1 = xn;
        end else if (w_ext <= POS_W'(1)) begin
            x1 = '0;
        end else begin
            x1 = w_ext - POS_W'(2);
        end
        if (yn < h_ext) begin
            y1 = yn;
        end else if (h_ext <= POS_W'(1)) begin
            y1 = '0;
        end else begin
            y1 = h_ext - POS_W'(2);
        end
    end

    assign coord_err = (x0 >= w_ext) || (y0 >= h_ext);
    assign col_even  = x0[0] ? x1 : x0;
    assign col_odd   = x0[0] ? x0 : x1;
    assign row_even  = y0[0] ? y1 : y0;
    assign row_odd   = y0[0] ? y0 : y1;

    // store write side
    logic [POS_W-1:0]  wcol, wrow;
    logic              wr_in_range;
    logic [ADDR_W-1:0] waddr;
    pixel_t            wpix;

    assign wcol        = POS_W'(s_pixel_col);
    assign wrow        = POS_W'(s_pixel_row);
    assign wr_in_range = (32'(s_pixel_col) < 32'(MAX_WIDTH))
                      && (32'(s_pixel_row) < 32'(MAX_HEIGHT));
    assign waddr       = bank_addr(wrow, wcol);
    assign wpix        = {s_pixel_red, s_pixel_green, s_pixel_blue};

    logic   we00, we01, we10, we11;
    pixel_t q00, q01, q10, q11;

    assign we00 = write_fire && wr_in_range && !wrow[0] && !wcol[0];
    assign we01 = write_fire && wr_in_range && !wrow[0] &&  wcol[0];
    assign we10 = write_fire && wr_in_range &&  wrow[0] && !wcol[0];
    assign we11 = write_fire && wr_in_range &&  wrow[0] &&  wcol[0];

    brsp_bank #(.DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_bank_00 (
        .aclk  (aclk),
        .we    (we00),
        .waddr (waddr),
        .wdata (wpix),
        .re    (sample_fire),
        .raddr (bank_addr(row_even, col_even)),
        .rdata (q00)
    );

    brsp_bank #(.DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_bank_01 (
        .aclk  (aclk),
        .we    (we01),
        .waddr (waddr),
        .wdata (wpix),
        .re    (sample_fire),
        .raddr (bank_addr(row_even, col_odd)),
        .rdata (q01)
    );

    brsp_bank #(.DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_bank_10 (
        .aclk  (aclk),
        .we    (we10),
        .waddr (waddr),
        .wdata (wpix),
        .re    (sample_fire),
        .raddr (bank_addr(row_odd, col_even)),
        .rdata (q10)
    );

    brsp_bank #(.DEPTH(BANK_DEPTH), .ADDR_W(ADDR_W)) u_bank_11 (
        .aclk  (aclk),
        .we    (we11),
        .waddr (waddr),
        .wdata (wpix),
        .re    (sample_fire),
        .raddr (bank_addr(row_odd, col_odd)),
        .rdata (q11)
    );

    // stage 1: store read in flight
    logic [FRAC_BITS-1:0] a1_reg, c1_reg;
    logic                 err1_reg, xpar1_reg, ypar1_reg, xsame1_reg, ysame1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= sample_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            a1_reg     <= s_sample_x[FRAC_BITS-1:0];
            c1_reg     <= s_sample_y[FRAC_BITS-1:0];
            err1_reg   <= coord_err;
            xpar1_reg  <= x0[0];
            ypar1_reg  <= y0[0];
            xsame1_reg <= (w_ext <= POS_W'(1));
            ysame1_reg <= (h_ext <= POS_W'(1));
        end
    end

    // stage 2: horizontal blend
    logic                 cx0, cx1, ry0, ry1;
    pixel_t               p00, p01, p10, p11;
    logic [FRAC_BITS:0]   inv_a;
    logic [TOP_W-1:0]     top_c [NUM_CH];
    logic [TOP_W-1:0]     bot_c [NUM_CH];
    logic [TOP_W-1:0]     top2_reg [NUM_CH];
    logic [TOP_W-1:0]     bot2_reg [NUM_CH];
    logic [FRAC_BITS-1:0] c2_reg;
    logic                 err2_reg;

    assign cx0   = xpar1_reg;
    assign cx1   = xsame1_reg ? xpar1_reg : !xpar1_reg;
    assign ry0   = ypar1_reg;
    assign ry1   = ysame1_reg ? ypar1_reg : !ypar1_reg;
    assign p00   = sel4(ry0, cx0, q00, q01, q10, q11);
    assign p01   = sel4(ry0, cx1, q00, q01, q10, q11);
    assign p10   = sel4(ry1, cx0, q00, q01, q10, q11);
    assign p11   = sel4(ry1, cx1, q00, q01, q10, q11);
    assign inv_a = ONE_W - {1'b0, a1_reg};

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            top_c[ch] = TOP_W'(TOP_W'(p00[CH_W*ch +: CH_W]) * TOP_W'(inv_a)
                             + TOP_W'(p01[CH_W*ch +: CH_W]) * TOP_W'(a1_reg));
            bot_c[ch] = TOP_W'(TOP_W'(p10[CH_W*ch +: CH_W]) * TOP_W'(inv_a)
                             + TOP_W'(p11[CH_W*ch +: CH_W]) * TOP_W'(a1_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            top2_reg <= top_c;
            bot2_reg <= bot_c;
            c2_reg   <= c1_reg;
            err2_reg <= err1_reg;
        end
    end

    // stage 3: vertical blend, round half up, output register
    logic [FRAC_BITS:0] inv_c;
    logic [SUM_W-1:0]   sum_c [NUM_CH];
    logic [CH_W-1:0]    res_c [NUM_CH];
    logic [CH_W-1:0]    blue_reg, green_reg, red_reg;
    logic               err3_reg;

    assign inv_c = ONE_W - {1'b0, c2_reg};

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_c[ch] = SUM_W'(SUM_W'(top2_reg[ch]) * SUM_W'(inv_c)
                             + SUM_W'(bot2_reg[ch]) * SUM_W'(c2_reg)) + HALF_W;
            res_c[ch] = sum_c[ch][SUM_W-1 -: CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            blue_reg  <= err2_reg ? '0 : res_c[0];
            green_reg <= err2_reg ? '0 : res_c[1];
            red_reg   <= err2_reg ? '0 : res_c[2];
            err3_reg  <= err2_reg;
        end
    end

    assign m_valid       = v3_reg;
    assign m_out_blue    = blue_reg;
    assign m_out_green   = green_reg;
    assign m_out_red     = red_reg;
    assign m_coord_error = err3_reg;

endmodule

/* sv/brsp_bank.sv */
// one parity bank of the image store, one write port and one registered read port
module brsp_bank
    import brsp_pkg::*;
#(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  pixel_t            wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output pixel_t            rdata
);

    pixel_t mem [DEPTH];
    pixel_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
